/* rtl/char_lcd_nibble_sequencer_top_defines.svh */
// ----------------------------------------------------------------------------
// LCD sequencer assertion macros
// Shared concurrent assertion forms; clk and arst_n come from the using scope.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_TOP_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication
`define LCDNS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LCDNS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lcdns_pkg.sv */
// ----------------------------------------------------------------------------
// LCD nibble sequencer package
// Request and pin-state types, action and register codes, init command table.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdns_pkg;

	typedef struct packed {
		logic [1:0] action;
		logic       is_data;
		logic [7:0] code;
		logic [5:0] column;
		logic       row;
	} cmd_t;

	typedef struct packed {
		logic        rs_level;
		logic        enable_level;
		logic [3:0]  bus_nibble;
		logic [15:0] hold_us;
		logic        last;
	} pin_t;

	typedef struct packed {
		logic [7:0]  code;
		logic [12:0] extra_us;
	} init_entry_t;

	localparam logic [1:0] ACT_INIT   = 2'd0;
	localparam logic [1:0] ACT_WRITE  = 2'd1;
	localparam logic [1:0] ACT_CURSOR = 2'd2;

	localparam logic [1:0] REG_PULSE_WIDTH = 2'd0;
	localparam logic [1:0] REG_NIBBLE_GAP  = 2'd1;
	localparam logic [1:0] REG_EXEC_TIME   = 2'd2;

	localparam logic [7:0]  PULSE_WIDTH_RST = 8'd2;
	localparam logic [7:0]  NIBBLE_GAP_RST  = 8'd2;
	localparam logic [11:0] EXEC_TIME_RST   = 12'd50;

	localparam logic [15:0] POWER_ON_HOLD_US = 16'd50000;
	localparam logic        CMD_SET_ADDR     = 1'b1;   // bit 7 of set-address

	localparam logic [3:0] INIT_IDX_FIRST  = 4'd0;
	localparam logic [3:0] INIT_IDX_NIBBLE = 4'd4;     // first 4-bit command
	localparam logic [3:0] INIT_IDX_LAST   = 4'd8;

	function automatic init_entry_t init_entry(input logic [3:0] idx);
		init_entry_t e;
		case (idx)
			4'd0: e = '{code: 8'h30, extra_us: 13'd5000};
			4'd1: e = '{code: 8'h30, extra_us: 13'd1000};
			4'd2: e = '{code: 8'h30, extra_us: 13'd1000};
			4'd3: e = '{code: 8'h20, extra_us: 13'd1000};
			4'd4: e = '{code: 8'h28, extra_us: 13'd0};
			4'd5: e = '{code: 8'h08, extra_us: 13'd0};
			4'd6: e = '{code: 8'h01, extra_us: 13'd2000};
			4'd7: e = '{code: 8'h06, extra_us: 13'd0};
			4'd8: e = '{code: 8'h0C, extra_us: 13'd0};
			default: e = '{code: 8'h00, extra_us: 13'd0};
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

/* rtl/char_lcd_nibble_sequencer_top.sv */
// ----------------------------------------------------------------------------
// Character LCD 4-bit nibble sequencer
// Expands init, write and cursor requests into timed RS/E/D7..D4 pin states.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  cmd      | in  | cmd_valid/stall    | cmd_t   (action, is_data, code, column, row)
//  pin      | out | pin_valid/stall    | pin_t   (rs, enable, nibble, hold_us, last)
//  cfg      | in  | cfg_write          | cfg_index, cfg_data
//
//  A request is taken in the idle state, then one pin state per unstalled cycle:
//  write/cursor 3 states (single-nibble) or 6 (nibble mode), init 43.
//  Rate is set by the step sequencer driving one shared hold adder.
//  cmd_stall is high from acceptance until the last pin state is registered.
//  pin stall freezes the sequencer; reset restores register defaults and
//  single-nibble mode.
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_nibble_sequencer_top_defines.svh"

module char_lcd_nibble_sequencer_top
	import lcdns_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire cmd_t        cmd,
	output logic             pin_valid,
	input  wire logic        pin_stall,
	output pin_t             pin,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [11:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_POWER = 3'b010,
		S_BYTE  = 3'b100
	} state_t;

	localparam logic [2:0] STEP_HI_SETUP = 3'd0;
	localparam logic [2:0] STEP_HI_PULSE = 3'd1;
	localparam logic [2:0] STEP_HI_GAP   = 3'd2;
	localparam logic [2:0] STEP_LO_SETUP = 3'd3;
	localparam logic [2:0] STEP_FIN_HIGH = 3'd4;
	localparam logic [2:0] STEP_FIN_LOW  = 3'd5;

	state_t      state_q;
	logic [2:0]  step_q;
	logic [3:0]  idx_q;
	logic        init_q;
	logic        nib_mode_q;
	logic [7:0]  byte_q;
	logic        rs_q;
	logic [12:0] extra_q;
	logic [7:0]  pulse_q;
	logic [7:0]  gap_q;
	logic [11:0] exec_q;
	logic        out_valid_q;
	pin_t        out_q;

	logic        cmd_acc;
	logic        emit;
	logic        last_c;
	logic [3:0]  nxt_idx_c;
	init_entry_t ent_c;
	logic [3:0]  fin_nib_c;
	logic [15:0] sum_c;
	pin_t        pin_c;

	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign emit      = (state_q != S_IDLE) && (!out_valid_q || !pin_stall);
	assign pin_valid = out_valid_q;
	assign pin       = out_q;

	assign nxt_idx_c = (state_q == S_POWER) ? INIT_IDX_FIRST : idx_q + 4'd1;
	assign ent_c     = init_entry(nxt_idx_c);
	assign last_c    = (step_q == STEP_FIN_LOW) && (!init_q || idx_q == INIT_IDX_LAST);
	assign fin_nib_c = nib_mode_q ? byte_q[3:0] : byte_q[7:4];
	assign sum_c     = {4'd0, exec_q} + {3'd0, extra_q};

	always_comb begin
		pin_c.rs_level     = rs_q;
		pin_c.enable_level = 1'b0;
		pin_c.bus_nibble   = byte_q[7:4];
		pin_c.hold_us      = 16'd0;
		pin_c.last         = 1'b0;
		if (state_q == S_POWER) begin
			pin_c.rs_level   = 1'b0;
			pin_c.bus_nibble = 4'd0;
			pin_c.hold_us    = POWER_ON_HOLD_US;
		end else begin
			case (step_q)
				STEP_HI_SETUP: pin_c.hold_us = 16'd0;
				STEP_HI_PULSE: begin
					pin_c.enable_level = 1'b1;
					pin_c.hold_us      = {8'd0, pulse_q};
				end
				STEP_HI_GAP: pin_c.hold_us = {8'd0, gap_q};
				STEP_LO_SETUP: pin_c.bus_nibble = byte_q[3:0];
				STEP_FIN_HIGH: begin
					pin_c.enable_level = 1'b1;
					pin_c.bus_nibble   = fin_nib_c;
					pin_c.hold_us      = {8'd0, pulse_q};
				end
				STEP_FIN_LOW: begin
					pin_c.bus_nibble = fin_nib_c;
					pin_c.hold_us    = sum_c;
					pin_c.last       = last_c;
				end
				default: pin_c.hold_us = 16'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q <= PULSE_WIDTH_RST;
			gap_q   <= NIBBLE_GAP_RST;
			exec_q  <= EXEC_TIME_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PULSE_WIDTH: pulse_q <= cfg_data[7:0];
				REG_NIBBLE_GAP:  gap_q   <= cfg_data[7:0];
				REG_EXEC_TIME:   exec_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= STEP_HI_SETUP;
			idx_q      <= INIT_IDX_FIRST;
			init_q     <= 1'b0;
			nib_mode_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						step_q <= STEP_HI_SETUP;
						case (cmd.action)
							ACT_INIT: begin
								state_q <= S_POWER;
								init_q  <= 1'b1;
							end
							ACT_WRITE:  state_q <= S_BYTE;
							ACT_CURSOR: state_q <= S_BYTE;
							default: ;
						endcase
					end
				end
				S_POWER: begin
					if (emit) begin
						state_q    <= S_BYTE;
						idx_q      <= nxt_idx_c;
						nib_mode_q <= 1'b0;
						step_q     <= STEP_HI_SETUP;
					end
				end
				S_BYTE: begin
					if (emit) begin
						case (step_q)
							STEP_HI_SETUP:
								step_q <= nib_mode_q ? STEP_HI_PULSE : STEP_FIN_HIGH;
							STEP_FIN_LOW: begin
								step_q <= STEP_HI_SETUP;
								if (last_c) begin
									state_q <= S_IDLE;
									init_q  <= 1'b0;
								end else begin
									idx_q      <= nxt_idx_c;
									nib_mode_q <= (nxt_idx_c >= INIT_IDX_NIBBLE);
								end
							end
							default: step_q <= step_q + 3'd1;
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// byte, RS and extra wait of the transfer in flight
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			rs_q    <= (cmd.action == ACT_WRITE) ? cmd.is_data : 1'b0;
			extra_q <= 13'd0;
			byte_q  <= (cmd.action == ACT_CURSOR) ? {CMD_SET_ADDR, cmd.row, cmd.column}
				: cmd.code;
		end else if (emit && (state_q == S_POWER ||
				(state_q == S_BYTE && step_q == STEP_FIN_LOW && !last_c))) begin
			rs_q    <= 1'b0;
			byte_q  <= ent_c.code;
			extra_q <= ent_c.extra_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!pin_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= pin_c;
		end
	end

	`LCDNS_ASSERT_NEXT(a_init_power, cmd_acc && cmd.action == ACT_INIT, state_q == S_POWER, "init request did not start power-on state")
	`LCDNS_ASSERT_NEXT(a_last_idle, state_q == S_BYTE && emit && last_c, state_q == S_IDLE && pin_valid && pin.last, "last pin state did not end the run")
	`LCDNS_ASSERT_NOW(a_single_steps, state_q == S_BYTE && !nib_mode_q, step_q == STEP_HI_SETUP || step_q == STEP_FIN_HIGH || step_q == STEP_FIN_LOW, "low-nibble step in single-nibble mode")
	`LCDNS_ASSERT_NOW(a_init_mode, state_q == S_BYTE && init_q, nib_mode_q == (idx_q >= INIT_IDX_NIBBLE), "nibble mode out of step with init sequence")

endmodule

`default_nettype wire
